### rtl/ptt_pkg.sv
// ----------------------------------------------------------------------------
// Periodic timer table package
// Shared widths, operation and result codes, and the slot entry layout.
// ----------------------------------------------------------------------------
package ptt_pkg;

  localparam int SLOTS_DEF   = 16;
  localparam int MAX_RESULTS = 16;

  localparam int OP_W     = 2;
  localparam int KIND_W   = 3;
  localparam int ID_W     = 16;
  localparam int PERIOD_W = 32;
  localparam int TIME_W   = 64;
  localparam int PADDR_W  = 3;
  localparam int PDATA_W  = 32;

  localparam logic [0:0] REG_ENABLE = 1'b0;

  typedef enum logic [OP_W-1:0] {
    OP_TICK   = 2'd0,
    OP_ADD    = 2'd1,
    OP_REMOVE = 2'd2
  } op_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_FIRED     = 3'd0,
    KIND_ADDED     = 3'd1,
    KIND_FULL      = 3'd2,
    KIND_REMOVED   = 3'd3,
    KIND_NOT_FOUND = 3'd4
  } kind_t;

  typedef struct packed {
    logic [ID_W-1:0]     id;
    logic [PERIOD_W-1:0] period;
    logic [TIME_W-1:0]   due;
  } slot_t;

endpackage

### rtl/ptt_if.sv
// ----------------------------------------------------------------------------
// Periodic timer table channels
// Command channel into the table and result channel out of it.
// ----------------------------------------------------------------------------
interface ptt_cmd_if;
  logic                         valid;
  logic                         ready;
  logic [ptt_pkg::OP_W-1:0]     op;
  logic [ptt_pkg::PERIOD_W-1:0] interval_ms;
  logic [ptt_pkg::ID_W-1:0]     timer_id;

  modport source (output valid, op, interval_ms, timer_id, input ready);
  modport sink   (input valid, op, interval_ms, timer_id, output ready);
endinterface

interface ptt_res_if;
  logic                       valid;
  logic                       ready;
  logic [ptt_pkg::KIND_W-1:0] kind;
  logic [ptt_pkg::ID_W-1:0]   result_id;
  logic                       last;

  modport source (output valid, kind, result_id, last, input ready);
  modport sink   (input valid, kind, result_id, last, output ready);
endinterface

### rtl/ptt_cfg.sv
// ----------------------------------------------------------------------------
// Periodic timer table register port
// APB-style register file holding the enable bit.
// ----------------------------------------------------------------------------
module ptt_cfg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ptt_pkg::PADDR_W-1:0] paddr,
  input  logic [ptt_pkg::PDATA_W-1:0] pwdata,
  output logic [ptt_pkg::PDATA_W-1:0] prdata,
  output logic                        pready,
  output logic                        enable
);

  logic [0:0] reg_idx;
  logic       wr_hit;

  assign reg_idx = paddr[ptt_pkg::PADDR_W-1:2];
  assign pready  = 1'b1;
  assign wr_hit  = psel && penable && pwrite && (reg_idx == ptt_pkg::REG_ENABLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      enable <= 1'b0;
    end else if (wr_hit) begin
      enable <= pwdata[0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_idx == ptt_pkg::REG_ENABLE) begin
      prdata[0] = enable;
    end
  end

endmodule

### rtl/periodic_timer_table_core.sv
// ----------------------------------------------------------------------------
// Periodic timer table
// Table of periodic millisecond timers with add, remove and tick commands.
//
//   channel   dir   handshake        payload
//   cmd       in    valid / ready    op, interval_ms, timer_id
//   res       out   valid / ready    kind, result_id, last
//   apb       in    psel / penable   paddr, pwdata, prdata (enable at 0x0)
//
// Add and remove scan the table, one slot entry read and compared per cycle.
// An enabled tick firing k timers runs one scan per fired timer plus a closing
// scan, which is dropped once MAX_RESULTS have fired; a disabled tick only
// advances time.
// cmd is ready only when the sequencer is idle; a result waiting in the
// output register stalls the sequencer only when the next one is due.
// Reset clears the valid bits and time and sets the id counter to one at once; no clearing pass.
// ----------------------------------------------------------------------------
module periodic_timer_table_core #(
  parameter int SLOTS = ptt_pkg::SLOTS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  ptt_cmd_if.sink                     cmd,
  ptt_res_if.source                   res,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ptt_pkg::PADDR_W-1:0] paddr,
  input  logic [ptt_pkg::PDATA_W-1:0] pwdata,
  output logic [ptt_pkg::PDATA_W-1:0] prdata,
  output logic                        pready
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(ptt_pkg::MAX_RESULTS + 1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_FIRE = 4'b0100,
    S_PUSH = 4'b1000
  } state_t;

  state_t state;

  logic enable;

  ptt_pkg::slot_t mem [SLOTS];
  ptt_pkg::slot_t rd_q;
  logic           wr_en;
  logic [IW-1:0]  wr_addr;
  ptt_pkg::slot_t wr_data;
  logic [ptt_pkg::TIME_W-1:0] add_a;
  logic [ptt_pkg::TIME_W-1:0] add_b;

  logic [SLOTS-1:0] valid;
  logic [SLOTS-1:0] done;
  logic [ptt_pkg::TIME_W-1:0] now;
  logic [ptt_pkg::ID_W-1:0]   fresh;

  logic [ptt_pkg::OP_W-1:0]     op_q;
  logic [ptt_pkg::PERIOD_W-1:0] ival_q;
  logic [ptt_pkg::ID_W-1:0]     rid_q;

  logic [IW-1:0]  rd_idx;
  logic           rd_busy;
  logic [IW-1:0]  cmp_idx;
  logic           cmp_vld;
  logic           best_vld;
  logic [IW-1:0]  best_idx;
  ptt_pkg::slot_t best_ent;
  logic           hit;
  logic [CW-1:0]  nfired;

  logic                     have_pend;
  logic                     pend_last;
  ptt_pkg::kind_t           pend_kind;
  logic [ptt_pkg::ID_W-1:0] pend_id;

  logic                     out_vld;
  ptt_pkg::kind_t           out_kind;
  logic [ptt_pkg::ID_W-1:0] out_id;
  logic                     out_last;

  logic          scan_end;
  logic          take_tick;
  logic          take_add;
  logic          take;
  logic          hit_c;
  logic          found_n;
  logic [IW-1:0] found_idx;
  logic          hit_n;
  logic          fire_last;
  logic          out_free;

  ptt_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .enable  (enable)
  );

  assign cmd.ready     = (state == S_IDLE);
  assign res.valid     = out_vld;
  assign res.kind      = out_kind;
  assign res.result_id = out_id;
  assign res.last      = out_last;

  assign out_free  = !out_vld || res.ready;
  assign scan_end  = (state == S_SCAN) && cmp_vld && (cmp_idx == IW'(SLOTS - 1));
  assign fire_last = (nfired == CW'(ptt_pkg::MAX_RESULTS - 1));

  assign take_tick = cmp_vld && valid[cmp_idx] && !done[cmp_idx] && (rd_q.due <= now) &&
                     (!best_vld || (rd_q.due < best_ent.due) ||
                      ((rd_q.due == best_ent.due) && (rd_q.id < best_ent.id)));
  assign take_add  = cmp_vld && !valid[cmp_idx] && !best_vld;
  assign hit_c     = cmp_vld && valid[cmp_idx] && (rd_q.id == rid_q);

  always_comb begin
    case (op_q)
      ptt_pkg::OP_TICK: take = take_tick;
      ptt_pkg::OP_ADD:  take = take_add;
      default:          take = 1'b0;
    endcase
  end

  assign found_n   = best_vld || take;
  assign found_idx = take ? cmp_idx : best_idx;
  assign hit_n     = hit || hit_c;

  always_comb begin
    if (state == S_FIRE) begin
      wr_en          = 1'b1;
      wr_addr        = best_idx;
      wr_data.id     = best_ent.id;
      wr_data.period = best_ent.period;
      add_a          = best_ent.due;
      add_b          = {{(ptt_pkg::TIME_W - ptt_pkg::PERIOD_W){1'b0}}, best_ent.period};
    end else begin
      wr_en          = scan_end && (op_q == ptt_pkg::OP_ADD) && found_n;
      wr_addr        = found_idx;
      wr_data.id     = fresh;
      wr_data.period = ival_q;
      add_a          = now;
      add_b          = {{(ptt_pkg::TIME_W - ptt_pkg::PERIOD_W){1'b0}}, ival_q};
    end
    wr_data.due = add_a + add_b;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q <= mem[rd_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      valid     <= '0;
      done      <= '0;
      now       <= '0;
      fresh     <= ptt_pkg::ID_W'(1);
      rd_idx    <= '0;
      rd_busy   <= 1'b0;
      cmp_vld   <= 1'b0;
      best_vld  <= 1'b0;
      hit       <= 1'b0;
      nfired    <= '0;
      have_pend <= 1'b0;
      pend_last <= 1'b0;
      out_vld   <= 1'b0;
    end else begin
      if (res.valid && res.ready) begin
        out_vld <= 1'b0;
      end

      cmp_vld <= rd_busy;
      cmp_idx <= rd_idx;
      if (rd_busy) begin
        if (rd_idx == IW'(SLOTS - 1)) begin
          rd_busy <= 1'b0;
        end else begin
          rd_idx <= rd_idx + 1'b1;
        end
      end

      if (state == S_SCAN) begin
        if (take) begin
          best_vld <= 1'b1;
          best_idx <= cmp_idx;
          best_ent <= rd_q;
        end
        if ((op_q == ptt_pkg::OP_REMOVE) && hit_c) begin
          valid[cmp_idx] <= 1'b0;
          hit            <= 1'b1;
        end
      end

      case (state)
        S_IDLE: begin
          if (cmd.valid) begin
            op_q   <= cmd.op;
            ival_q <= cmd.interval_ms;
            rid_q  <= cmd.timer_id;
            case (cmd.op)
              ptt_pkg::OP_TICK: begin
                now <= now + 1'b1;
                if (enable) begin
                  done      <= '0;
                  nfired    <= '0;
                  have_pend <= 1'b0;
                  rd_idx    <= '0;
                  rd_busy   <= 1'b1;
                  cmp_vld   <= 1'b0;
                  best_vld  <= 1'b0;
                  state     <= S_SCAN;
                end
              end
              ptt_pkg::OP_ADD, ptt_pkg::OP_REMOVE: begin
                hit      <= 1'b0;
                rd_idx   <= '0;
                rd_busy  <= 1'b1;
                cmp_vld  <= 1'b0;
                best_vld <= 1'b0;
                state    <= S_SCAN;
              end
              default: begin
              end
            endcase
          end
        end

        S_SCAN: begin
          if (scan_end) begin
            case (op_q)
              ptt_pkg::OP_TICK: begin
                if (found_n) begin
                  if (have_pend) begin
                    pend_last <= 1'b0;
                    state     <= S_PUSH;
                  end else begin
                    state <= S_FIRE;
                  end
                end else if (have_pend) begin
                  pend_last <= 1'b1;
                  state     <= S_PUSH;
                end else begin
                  state <= S_IDLE;
                end
              end
              ptt_pkg::OP_ADD: begin
                pend_last <= 1'b1;
                state     <= S_PUSH;
                if (found_n) begin
                  valid[found_idx] <= 1'b1;
                  fresh     <= (fresh == '1) ? ptt_pkg::ID_W'(1) : fresh + 1'b1;
                  pend_kind <= ptt_pkg::KIND_ADDED;
                  pend_id   <= fresh;
                end else begin
                  pend_kind <= ptt_pkg::KIND_FULL;
                  pend_id   <= '0;
                end
              end
              ptt_pkg::OP_REMOVE: begin
                pend_last <= 1'b1;
                pend_kind <= hit_n ? ptt_pkg::KIND_REMOVED : ptt_pkg::KIND_NOT_FOUND;
                pend_id   <= rid_q;
                state     <= S_PUSH;
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end

        S_FIRE: begin
          done[best_idx] <= 1'b1;
          pend_kind      <= ptt_pkg::KIND_FIRED;
          pend_id        <= best_ent.id;
          have_pend      <= 1'b1;
          nfired         <= nfired + 1'b1;
          if (fire_last) begin
            pend_last <= 1'b1;
            state     <= S_PUSH;
          end else begin
            rd_idx   <= '0;
            rd_busy  <= 1'b1;
            cmp_vld  <= 1'b0;
            best_vld <= 1'b0;
            state    <= S_SCAN;
          end
        end

        S_PUSH: begin
          if (out_free) begin
            out_vld  <= 1'b1;
            out_kind <= pend_kind;
            out_id   <= pend_id;
            out_last <= pend_last;
            if (pend_last) begin
              have_pend <= 1'b0;
              state     <= S_IDLE;
            end else begin
              state <= S_FIRE;
            end
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_fired_bound: assert property (@(posedge clk) disable iff (rst)
    nfired <= CW'(ptt_pkg::MAX_RESULTS))
    else $error("more timers fired than one tick allows");

  a_write_src: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (state == S_FIRE) || scan_end)
    else $error("slot RAM written outside fire or add");

  a_fire_live: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIRE) |-> best_vld && valid[best_idx] && !done[best_idx])
    else $error("firing a slot that is not live or already fired");

  a_tick_time: assert property (@(posedge clk) disable iff (rst)
    cmd.valid && cmd.ready && (cmd.op == ptt_pkg::OP_TICK) |=> now == $past(now) + 1'b1)
    else $error("time did not advance by one on a tick");

endmodule
